/* rtl/tcw_pkg.sv */
// shared types and constants for the text console writer
`default_nettype none

package tcw_pkg;

  localparam int unsigned OPCODE_W     = 2;
  localparam int unsigned CHAR_W       = 8;
  localparam int unsigned CELL_INDEX_W = 11;
  localparam int unsigned CELL_W       = 16;
  localparam int unsigned ATTR_W       = 8;
  localparam int unsigned ROW_OUT_W    = 5;
  localparam int unsigned COL_OUT_W    = 7;
  localparam int unsigned QDEPTH       = 2;
  localparam int unsigned QPTR_W       = 1;

  localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0720;
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'd7;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    CMD_NOP     = 3'd0,
    CMD_PUT     = 3'd1,
    CMD_NEWLINE = 3'd2,
    CMD_CLEAR   = 3'd3,
    CMD_READ    = 3'd4
  } cmd_e;

  typedef struct packed {
    cmd_e                    kind;
    logic [CHAR_W-1:0]       char_code;
    logic [CELL_INDEX_W-1:0] cell_index;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_INIT  = 3'd0,
    ST_IDLE  = 3'd1,
    ST_READ  = 3'd2,
    ST_CLEAR = 3'd3,
    ST_COPY  = 3'd4,
    ST_DRAIN = 3'd5,
    ST_FILL  = 3'd6
  } state_e;

endpackage

`default_nettype wire

/* rtl/tcw_front.sv */
// input stage: classifies incoming words and queues them as commands
`default_nettype none

module tcw_front
  import tcw_pkg::*;
#(
  parameter int unsigned CELL_COUNT = 2000
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic [OPCODE_W-1:0]     opcode_i,
  input  wire logic [CHAR_W-1:0]       char_code_i,
  input  wire logic [CELL_INDEX_W-1:0] cell_index_i,
  input  wire logic                    back_ready_i,
  output logic                         cmd_valid_o,
  output cmd_t                         cmd_o,
  input  wire logic                    cmd_pop_i
);

  cmd_t                 queue_q [QDEPTH];
  logic [QPTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]      count_q, count_d;
  logic                 push;
  cmd_t                 cmd_new;

  always_comb begin
    cmd_new            = '0;
    cmd_new.char_code  = char_code_i;
    cmd_new.cell_index = cell_index_i;
    unique case (opcode_i)
      OP_PUT: begin
        cmd_new.kind = (char_code_i == NEWLINE_CODE) ? CMD_NEWLINE : CMD_PUT;
      end
      OP_CLEAR: begin
        cmd_new.kind = CMD_CLEAR;
      end
      OP_READ: begin
        // out of range reads behave as no-ops
        cmd_new.kind = (32'(cell_index_i) < CELL_COUNT) ? CMD_READ : CMD_NOP;
      end
      default: begin
        cmd_new.kind = CMD_NOP;
      end
    endcase
  end

  assign in_stall_o  = (count_q == (QPTR_W+1)'(QDEPTH)) || !back_ready_i;
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = queue_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = cmd_pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + (QPTR_W+1)'(push) - (QPTR_W+1)'(cmd_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

`default_nettype wire

/* rtl/tcw_back.sv */
// execution stage: frame store, cursor, scroll and clear sequencing, result register
`default_nettype none

module tcw_back
  import tcw_pkg::*;
#(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cmd_valid_i,
  input  wire cmd_t                  cmd_i,
  output logic                       cmd_pop_o,
  output logic                       ready_o,
  input  wire logic [ATTR_W-1:0]     attr_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [CELL_W-1:0]          read_data_o,
  output logic [ROW_OUT_W-1:0]       cursor_row_o,
  output logic [COL_OUT_W-1:0]       cursor_col_o,
  output logic                       scrolled_o
);

  localparam int unsigned CELL_COUNT = ROWS * COLUMNS;
  localparam int unsigned COPY_COUNT = (ROWS - 1) * COLUMNS;
  localparam int unsigned AW         = $clog2(CELL_COUNT);
  localparam int unsigned ROW_W      = $clog2(ROWS);
  localparam int unsigned COL_W      = $clog2(COLUMNS);

  logic [CELL_W-1:0]    frame_mem_q [CELL_COUNT];
  logic [CELL_W-1:0]    rdata_q;

  state_e               state_q, state_d;
  logic [AW-1:0]        cnt_q, cnt_d;
  logic [ROW_W-1:0]     row_q, row_d;
  logic [COL_W-1:0]     col_q, col_d;

  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [CELL_W-1:0]    mem_wdata;
  logic [AW-1:0]        mem_raddr;

  logic                 out_valid_q, out_valid_d;
  logic [CELL_W-1:0]    read_data_q, read_data_d;
  logic [ROW_OUT_W-1:0] cursor_row_q, cursor_row_d;
  logic [COL_OUT_W-1:0] cursor_col_q, cursor_col_d;
  logic                 scrolled_q, scrolled_d;

  logic                 out_free;
  logic [AW-1:0]        cursor_pos;
  logic [COL_W:0]       col_inc;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign cursor_pos = AW'(row_q) * AW'(COLUMNS) + AW'(col_q);
  assign col_inc    = {1'b0, col_q} + 1'b1;
  assign ready_o    = (state_q != ST_INIT);

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    row_d        = row_q;
    col_d        = col_q;
    mem_we       = 1'b0;
    mem_waddr    = cnt_q;
    mem_wdata    = BLANK_CELL;
    mem_raddr    = cnt_q + AW'(COLUMNS);
    cmd_pop_o    = 1'b0;
    out_valid_d  = out_valid_q && out_stall_i;
    read_data_d  = read_data_q;
    cursor_row_d = cursor_row_q;
    cursor_col_d = cursor_col_q;
    scrolled_d   = scrolled_q;

    unique case (state_q)
      ST_INIT: begin
        mem_we = 1'b1;
        if (cnt_q == AW'(CELL_COUNT - 1)) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      ST_IDLE: begin
        if (cmd_valid_i && out_free) begin
          cmd_pop_o = 1'b1;
          unique case (cmd_i.kind)
            CMD_PUT: begin
              mem_we    = 1'b1;
              mem_waddr = cursor_pos;
              mem_wdata = {attr_i, cmd_i.char_code};
              if (col_inc == (COL_W+1)'(COLUMNS)) begin
                col_d = '0;
                if (row_q == ROW_W'(ROWS - 1)) begin
                  cnt_d   = '0;
                  state_d = ST_COPY;
                end else begin
                  row_d        = row_q + 1'b1;
                  out_valid_d  = 1'b1;
                  read_data_d  = '0;
                  cursor_row_d = ROW_OUT_W'(row_q + 1'b1);
                  cursor_col_d = '0;
                  scrolled_d   = 1'b0;
                end
              end else begin
                col_d        = COL_W'(col_inc);
                out_valid_d  = 1'b1;
                read_data_d  = '0;
                cursor_row_d = ROW_OUT_W'(row_q);
                cursor_col_d = COL_OUT_W'(col_inc);
                scrolled_d   = 1'b0;
              end
            end
            CMD_NEWLINE: begin
              col_d = '0;
              if (row_q == ROW_W'(ROWS - 1)) begin
                cnt_d   = '0;
                state_d = ST_COPY;
              end else begin
                row_d        = row_q + 1'b1;
                out_valid_d  = 1'b1;
                read_data_d  = '0;
                cursor_row_d = ROW_OUT_W'(row_q + 1'b1);
                cursor_col_d = '0;
                scrolled_d   = 1'b0;
              end
            end
            CMD_CLEAR: begin
              cnt_d   = '0;
              row_d   = '0;
              col_d   = '0;
              state_d = ST_CLEAR;
            end
            CMD_READ: begin
              mem_raddr = AW'(cmd_i.cell_index);
              state_d   = ST_READ;
            end
            default: begin
              out_valid_d  = 1'b1;
              read_data_d  = '0;
              cursor_row_d = ROW_OUT_W'(row_q);
              cursor_col_d = COL_OUT_W'(col_q);
              scrolled_d   = 1'b0;
            end
          endcase
        end
      end

      ST_READ: begin
        out_valid_d  = 1'b1;
        read_data_d  = rdata_q;
        cursor_row_d = ROW_OUT_W'(row_q);
        cursor_col_d = COL_OUT_W'(col_q);
        scrolled_d   = 1'b0;
        state_d      = ST_IDLE;
      end

      ST_CLEAR: begin
        mem_we = 1'b1;
        if (cnt_q == AW'(CELL_COUNT - 1)) begin
          out_valid_d  = 1'b1;
          read_data_d  = '0;
          cursor_row_d = '0;
          cursor_col_d = '0;
          scrolled_d   = 1'b0;
          state_d      = ST_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      // read one row ahead, write the previous cell from the registered read data
      ST_COPY: begin
        mem_we    = (cnt_q != '0);
        mem_waddr = cnt_q - 1'b1;
        mem_wdata = rdata_q;
        if (cnt_q == AW'(COPY_COUNT - 1)) begin
          state_d = ST_DRAIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      ST_DRAIN: begin
        mem_we    = 1'b1;
        mem_wdata = rdata_q;
        cnt_d     = cnt_q + 1'b1;
        state_d   = ST_FILL;
      end

      ST_FILL: begin
        mem_we = 1'b1;
        if (cnt_q == AW'(CELL_COUNT - 1)) begin
          out_valid_d  = 1'b1;
          read_data_d  = '0;
          cursor_row_d = ROW_OUT_W'(row_q);
          cursor_col_d = '0;
          scrolled_d   = 1'b1;
          cnt_d        = '0;
          state_d      = ST_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      cnt_q       <= '0;
      row_q       <= '0;
      col_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      row_q       <= row_d;
      col_q       <= col_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    read_data_q  <= read_data_d;
    cursor_row_q <= cursor_row_d;
    cursor_col_q <= cursor_col_d;
    scrolled_q   <= scrolled_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      frame_mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= frame_mem_q[mem_raddr];
  end

  assign out_valid_o  = out_valid_q;
  assign read_data_o  = read_data_q;
  assign cursor_row_o = cursor_row_q;
  assign cursor_col_o = cursor_col_q;
  assign scrolled_o   = scrolled_q;

endmodule

`default_nettype wire

/* rtl/text_console_writer_core.sv */
// top level of the text console writer: attribute register, command queue and executor
// put and newline that do not scroll, unused codes and out of range reads register their
// result straight from ST_IDLE, an in-range read from ST_READ after the store read
// clear and a scrolling put both walk every cell of the frame store,
// their length set by the single write port of the frame store
// after reset the store is swept to blank with in_stall_o high
`default_nettype none

module text_console_writer_core
  import tcw_pkg::*;
#(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [ATTR_W-1:0]       cfg_wdata_i,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic [OPCODE_W-1:0]     opcode_i,
  input  wire logic [CHAR_W-1:0]       char_code_i,
  input  wire logic [CELL_INDEX_W-1:0] cell_index_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic [CELL_W-1:0]            read_data_o,
  output logic [ROW_OUT_W-1:0]         cursor_row_o,
  output logic [COL_OUT_W-1:0]         cursor_col_o,
  output logic                         scrolled_o
);

  logic [ATTR_W-1:0] attr_q;
  logic              back_ready;
  logic              cmd_valid;
  logic              cmd_pop;
  cmd_t              cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= ATTR_RESET;
    end else if (cfg_we_i) begin
      attr_q <= cfg_wdata_i;
    end
  end

  tcw_front #(
    .CELL_COUNT (ROWS * COLUMNS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .char_code_i  (char_code_i),
    .cell_index_i (cell_index_i),
    .back_ready_i (back_ready),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd),
    .cmd_pop_i    (cmd_pop)
  );

  tcw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (cmd),
    .cmd_pop_o    (cmd_pop),
    .ready_o      (back_ready),
    .attr_i       (attr_q),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .read_data_o  (read_data_o),
    .cursor_row_o (cursor_row_o),
    .cursor_col_o (cursor_col_o),
    .scrolled_o   (scrolled_o)
  );

endmodule

`default_nettype wire

/* dv/testbench.sv */
// self-checking testbench for the text console writer: directed edges, then random traffic
`default_nettype none

module testbench
  import tcw_pkg::*;
();

  localparam int unsigned COLUMNS = 80;
  localparam int unsigned ROWS    = 25;
  localparam int unsigned CELLS   = ROWS * COLUMNS;
  localparam int unsigned MAX_INDEX = (1 << CELL_INDEX_W) - 1;
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [CELL_W-1:0]    read_data;
    logic [ROW_OUT_W-1:0] cursor_row;
    logic [COL_OUT_W-1:0] cursor_col;
    logic                 scrolled;
  } console_status_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [ATTR_W-1:0]       cfg_wdata = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [OPCODE_W-1:0]     opcode = '0;
  logic [CHAR_W-1:0]       char_code = '0;
  logic [CELL_INDEX_W-1:0] cell_index = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [CELL_W-1:0]       read_data;
  logic [ROW_OUT_W-1:0]    cursor_row;
  logic [COL_OUT_W-1:0]    cursor_col;
  logic                    scrolled;

  // shadow of the console
  logic [CELL_W-1:0]    screen [CELLS];
  logic [ROW_OUT_W-1:0] cur_row;
  logic [COL_OUT_W-1:0] cur_col;
  logic [ATTR_W-1:0]    attr;

  console_status_t awaited_status[$];
  int error_count = 0;
  int idle_in_pct = 0;
  int stall_out_pct = 0;

  text_console_writer_core #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .opcode_i    (opcode),
    .char_code_i (char_code),
    .cell_index_i(cell_index),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .read_data_o (read_data),
    .cursor_row_o(cursor_row),
    .cursor_col_o(cursor_col),
    .scrolled_o  (scrolled)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #30_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic void blank_screen();
    for (int i = 0; i < CELLS; i++) screen[i] = BLANK_CELL;
    cur_row = '0;
    cur_col = '0;
  endfunction

  // move to the start of the next row, scrolling at the bottom
  function automatic logic advance_row();
    cur_col = '0;
    cur_row = cur_row + 1'b1;
    if (cur_row < ROWS) return 1'b0;
    for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) screen[i] = screen[i + COLUMNS];
    for (int i = (ROWS - 1) * COLUMNS; i < CELLS; i++) screen[i] = BLANK_CELL;
    cur_row = ROW_OUT_W'(ROWS - 1);
    return 1'b1;
  endfunction

  function automatic console_status_t console_apply(input logic [OPCODE_W-1:0] op,
                                                    input logic [CHAR_W-1:0] ch,
                                                    input logic [CELL_INDEX_W-1:0] idx);
    console_status_t st;
    st = '0;
    case (op)
      OP_PUT: begin
        if (ch == NEWLINE_CODE) begin
          st.scrolled = advance_row();
        end else begin
          screen[cur_row * COLUMNS + cur_col] = {attr, ch};
          cur_col = cur_col + 1'b1;
          if (cur_col >= COLUMNS) st.scrolled = advance_row();
        end
      end
      OP_CLEAR: blank_screen();
      OP_READ: begin
        if (idx < CELLS) st.read_data = screen[idx];
      end
      default: ;
    endcase
    st.cursor_row = cur_row;
    st.cursor_col = cur_col;
    return st;
  endfunction

  task automatic send_word(input logic [OPCODE_W-1:0] op, input logic [CHAR_W-1:0] ch,
                           input logic [CELL_INDEX_W-1:0] idx);
    while ($urandom_range(0, 99) < idle_in_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    opcode     <= op;
    char_code  <= ch;
    cell_index <= idx;
    do @(posedge clk); while (in_stall);
    awaited_status.push_back(console_apply(op, ch, idx));
  endtask

  task automatic wait_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_status.size() != 0) @(posedge clk);
    // a scroll or clear may still be walking the store
    repeat (CELLS + 16) @(posedge clk);
  endtask

  task automatic set_attribute(input logic [ATTR_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    attr = value;
  endtask

  task automatic test_put_extremes();
    send_word(OP_PUT, 8'h00, '0);
    send_word(OP_PUT, 8'hFF, 11'h7FF);
    send_word(OP_PUT, NEWLINE_CODE, '0);
    send_word(OP_PUT, 8'h41, '0);
    send_word(OP_READ, 8'hFF, 11'd0);
    send_word(OP_READ, 8'h00, 11'd1);
    send_word(OP_READ, 8'h00, 11'd80);
    send_word(OP_READ, 8'h00, 11'd2);
    send_word(OP_READ, 8'h00, CELL_INDEX_W'(CELLS - 1));
    send_word(OP_READ, 8'h00, CELL_INDEX_W'(CELLS));
    send_word(OP_READ, 8'h00, CELL_INDEX_W'(MAX_INDEX));
  endtask

  task automatic test_clear_and_unused_opcode();
    wait_quiet();
    set_attribute(8'hFF);
    send_word(OP_PUT, 8'h5A, '0);
    send_word(OP_READ, 8'h00, 11'd81);
    send_word(OP_UNUSED, 8'hFF, CELL_INDEX_W'(MAX_INDEX));
    send_word(OP_UNUSED, 8'h00, 11'd0);
    send_word(OP_CLEAR, 8'h41, 11'd5);
    send_word(OP_READ, 8'h00, 11'd81);
    send_word(OP_READ, 8'h00, 11'd0);
    send_word(OP_PUT, 8'h20, '0);
    send_word(OP_READ, 8'h00, 11'd0);
  endtask

  task automatic test_random_traffic(input int in_pct, input int out_pct,
                                     input logic [ATTR_W-1:0] attr_value, input int n_items);
    int sent;
    int pick;
    int len;
    sent = 0;
    wait_quiet();
    set_attribute(attr_value);
    idle_in_pct   = in_pct;
    stall_out_pct = out_pct;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        // a line of text, short or long enough that it may wrap
        len = $urandom_range(0, 1) ? $urandom_range(0, 8) : $urandom_range(60, 100);
        for (int k = 0; k < len; k++)
          send_word(OP_PUT, CHAR_W'($urandom_range(0, 255)),
                    CELL_INDEX_W'($urandom_range(0, MAX_INDEX)));
        if ($urandom_range(0, 3) != 0)
          send_word(OP_PUT, NEWLINE_CODE, CELL_INDEX_W'($urandom_range(0, MAX_INDEX)));
        sent += len + 1;
      end else if (pick < 90) begin
        len = $urandom_range(4, 20);
        for (int k = 0; k < len; k++) begin
          case ($urandom_range(0, 2))
            0: send_word(OP_READ, CHAR_W'($urandom_range(0, 255)),
                         CELL_INDEX_W'(cur_row * COLUMNS + $urandom_range(0, COLUMNS - 1)));
            1: send_word(OP_READ, CHAR_W'($urandom_range(0, 255)),
                         CELL_INDEX_W'($urandom_range(0, (cur_row + 1) * COLUMNS - 1)));
            default: send_word(OP_READ, CHAR_W'($urandom_range(0, 255)),
                               CELL_INDEX_W'($urandom_range(0, MAX_INDEX)));
          endcase
        end
        sent += len;
      end else if (pick < 92) begin
        send_word(OP_CLEAR, CHAR_W'($urandom_range(0, 255)),
                  CELL_INDEX_W'($urandom_range(0, MAX_INDEX)));
        sent++;
      end else begin
        send_word(OP_UNUSED, CHAR_W'($urandom_range(0, 255)),
                  CELL_INDEX_W'($urandom_range(0, MAX_INDEX)));
        sent++;
      end
    end
  endtask

  always @(posedge clk) begin : check_words
    console_status_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_status.size() == 0) begin
        $error("unexpected word: read_data %h row %0d col %0d", read_data, cursor_row,
               cursor_col);
        error_count++;
      end else begin
        want = awaited_status.pop_front();
        if (read_data !== want.read_data) begin
          $error("read_data expected %h actual %h", want.read_data, read_data);
          error_count++;
        end
        if (cursor_row !== want.cursor_row) begin
          $error("cursor_row expected %0d actual %0d", want.cursor_row, cursor_row);
          error_count++;
        end
        if (cursor_col !== want.cursor_col) begin
          $error("cursor_col expected %0d actual %0d", want.cursor_col, cursor_col);
          error_count++;
        end
        if (scrolled !== want.scrolled) begin
          $error("scrolled expected %0d actual %0d", want.scrolled, scrolled);
          error_count++;
        end
      end
    end
    out_stall <= ($urandom_range(0, 99) < stall_out_pct);
  end

  initial begin
    blank_screen();
    attr = ATTR_RESET;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_put_extremes();
    test_clear_and_unused_opcode();
    test_random_traffic(0, 0, 8'h00, 375);
    test_random_traffic(63, 0, ATTR_W'($urandom_range(0, 255)), 375);
    test_random_traffic(0, 63, 8'hFF, 375);
    test_random_traffic(30, 30, ATTR_W'($urandom_range(0, 255)), 375);
    wait_quiet();
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
